>>> hdl/qsn_pkg.sv
// Shared types, constants and helpers for the quadratic spiking neuron array.
// Depends on nothing; used by qsn_state_mem and quadratic_spiking_neuron_array.
package qsn_pkg;

    // Neuron count; the state memories are this deep (2 to 1024 with a 10 bit index).
    localparam int NEURONS  = 1024;
    localparam int ADDR_W   = $clog2(NEURONS);
    localparam int NEURON_W = 10;
    localparam int DRIVE_W  = 24;
    localparam int STATE_W  = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register reset values
    localparam logic signed [15:0] V_REST_INIT       = -16'sd15360;
    localparam logic signed [15:0] V_THRES_INIT      = -16'sd10240;
    localparam logic signed [15:0] V_PEAK_INIT       = 16'sd7680;
    localparam logic signed [15:0] V_RESET_INIT      = -16'sd12800;
    localparam logic signed [15:0] U_JUMP_INIT       = 16'sd0;
    localparam logic [15:0]        QUAD_GAIN_INIT    = 16'd459;
    localparam logic [15:0]        REC_RATE_INIT     = 16'd0;
    localparam logic signed [16:0] REC_COUPLING_INIT = 17'sd0;

    localparam logic signed [STATE_W-1:0] SAT_MAX = 24'sh7FFFFF;
    localparam logic signed [STATE_W-1:0] SAT_MIN = -24'sh800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_V_REST       = 3'd0,
        CFG_V_THRES      = 3'd1,
        CFG_V_PEAK       = 3'd2,
        CFG_V_RESET      = 3'd3,
        CFG_U_JUMP       = 3'd4,
        CFG_QUAD_GAIN    = 3'd5,
        CFG_REC_RATE     = 3'd6,
        CFG_REC_COUPLING = 3'd7
    } qsn_cfg_idx_t;

    typedef struct packed {
        logic [NEURON_W-1:0]       neuron;
        logic signed [DRIVE_W-1:0] drive;
    } qsn_in_t;

    typedef struct packed {
        logic [NEURON_W-1:0]       neuron_out;
        logic                      spiked;
        logic signed [STATE_W-1:0] membrane;
    } qsn_out_t;

    // State memory write request from the pipeline tail
    typedef struct packed {
        logic                      en;
        logic [ADDR_W-1:0]         addr;
        logic signed [STATE_W-1:0] v;
        logic signed [STATE_W-1:0] u;
    } qsn_wr_t;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic [NEURON_W-1:0] neuron;
        logic                in_range;
        logic                spiked;
    } qsn_tag_t;

    function automatic logic signed [STATE_W-1:0] sat24(input logic signed [47:0] x);
        logic signed [STATE_W-1:0] r;
        if (x > 48'(SAT_MAX))
            r = SAT_MAX;
        else if (x < 48'(SAT_MIN))
            r = SAT_MIN;
        else
            r = x[STATE_W-1:0];
        return r;
    endfunction

endpackage

>>> hdl/quadratic_spiking_neuron_array.sv
// Top level: config registers, seven-stage neuron update pipeline, output register.
// Depends on qsn_pkg and qsn_state_mem.
//
//  channel  | signals                        | moves
//  ---------+--------------------------------+-------------------------------
//  in       | in_valid, in_ready, in_data    | neuron index and drive
//  out      | out_valid, out_ready, out_data | index, spike flag, new membrane
//  cfg      | cfg_we, cfg_index, cfg_data    | register writes, no handshake
//
// One transfer per cycle for distinct neurons unless the output stalls; each result passes
// through stages 1 to 7 and the output register. A neuron still inside the seven pipeline
// stages holds in_ready low until written back; repeats never overlap (read-modify-write).
// After reset a sweep loads the state memories; in_ready stays low meanwhile.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module quadratic_spiking_neuron_array (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  qsn_pkg::qsn_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output qsn_pkg::qsn_out_t                  out_data,
    input  logic                               cfg_we,
    input  logic [qsn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qsn_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import qsn_pkg::*;

    // Configuration
    logic signed [15:0] v_rest_reg, v_thres_reg, v_peak_reg, v_reset_reg, u_jump_reg;
    logic [15:0]        quad_gain_reg, rec_rate_reg;
    logic signed [16:0] rec_coupling_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_rest_reg       <= V_REST_INIT;
            v_thres_reg      <= V_THRES_INIT;
            v_peak_reg       <= V_PEAK_INIT;
            v_reset_reg      <= V_RESET_INIT;
            u_jump_reg       <= U_JUMP_INIT;
            quad_gain_reg    <= QUAD_GAIN_INIT;
            rec_rate_reg     <= REC_RATE_INIT;
            rec_coupling_reg <= REC_COUPLING_INIT;
        end
        else if (cfg_we)
        begin
            unique case (qsn_cfg_idx_t'(cfg_index))
                CFG_V_REST:       v_rest_reg       <= cfg_data[15:0];
                CFG_V_THRES:      v_thres_reg      <= cfg_data[15:0];
                CFG_V_PEAK:       v_peak_reg       <= cfg_data[15:0];
                CFG_V_RESET:      v_reset_reg      <= cfg_data[15:0];
                CFG_U_JUMP:       u_jump_reg       <= cfg_data[15:0];
                CFG_QUAD_GAIN:    quad_gain_reg    <= cfg_data[15:0];
                CFG_REC_RATE:     rec_rate_reg     <= cfg_data[15:0];
                CFG_REC_COUPLING: rec_coupling_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic     advance, hazard, in_range, mem_busy, accept;
    logic     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic     s5_valid_reg, s6_valid_reg, s7_valid_reg, out_valid_reg;
    qsn_tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    qsn_tag_t s5_tag_reg, s6_tag_reg, s7_tag_reg;
    qsn_out_t out_data_reg;
    qsn_wr_t  wr;
    logic     wr_collide;

    function automatic logic hit(input logic valid, input qsn_tag_t tag,
                                 input logic [NEURON_W-1:0] n);
        return valid && tag.in_range && (tag.neuron == n);
    endfunction

    assign advance  = !out_valid_reg || out_ready;
    assign in_range = int'(in_data.neuron) < NEURONS;
    // Items up to stage 7 have not written back yet
    assign hazard   = hit(s1_valid_reg, s1_tag_reg, in_data.neuron)
                   || hit(s2_valid_reg, s2_tag_reg, in_data.neuron)
                   || hit(s3_valid_reg, s3_tag_reg, in_data.neuron)
                   || hit(s4_valid_reg, s4_tag_reg, in_data.neuron)
                   || hit(s5_valid_reg, s5_tag_reg, in_data.neuron)
                   || hit(s6_valid_reg, s6_tag_reg, in_data.neuron)
                   || hit(s7_valid_reg, s7_tag_reg, in_data.neuron);
    assign in_ready = advance && !mem_busy && !hazard;
    assign accept   = in_valid && in_ready;

    logic signed [STATE_W-1:0] rd_v, rd_u;

    qsn_state_mem u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (advance),
        .rd_addr (in_data.neuron[ADDR_W-1:0]),
        .wr      (wr),
        .rd_v    (rd_v),
        .rd_u    (rd_u),
        .busy    (mem_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            out_valid_reg <= s7_valid_reg;
        end
    end

    // Stage 1: memory read data arrives; peak check and spike reset
    logic signed [DRIVE_W-1:0] s1_drive_reg;
    logic                      spike;
    qsn_tag_t                  s2_tag_next;
    logic signed [STATE_W-1:0] s2_v_next, s2_u_next;

    assign spike = s1_tag_reg.in_range && (rd_v > STATE_W'(v_peak_reg));

    always_comb
    begin
        s2_tag_next        = s1_tag_reg;
        s2_tag_next.spiked = spike;
        s2_v_next          = spike ? STATE_W'(v_reset_reg) : rd_v;
        s2_u_next          = spike ? sat24(48'(rd_u) + 48'(u_jump_reg)) : rd_u;
    end

    // Stage 2: differences and the linear part of the membrane sum
    logic signed [DRIVE_W-1:0] s2_drive_reg;
    logic signed [STATE_W-1:0] s2_v_reg, s2_u_reg;
    logic signed [24:0]        s3_dr_next, s3_dt_next;
    logic signed [25:0]        s3_vbase_next;

    assign s3_dr_next    = 25'(s2_v_reg) - 25'(v_rest_reg);
    assign s3_dt_next    = 25'(s2_v_reg) - 25'(v_thres_reg);
    assign s3_vbase_next = 26'(s2_v_reg) - 26'(s2_u_reg) + 26'(s2_drive_reg);

    // Stage 3: first multipliers
    logic signed [24:0]        s3_dr_reg, s3_dt_reg;
    logic signed [25:0]        s3_vbase_reg;
    logic signed [STATE_W-1:0] s3_u_reg;
    logic signed [49:0]        s4_prod_next;
    logic signed [41:0]        s4_rcv_next;
    logic signed [40:0]        s4_rru_next;

    assign s4_prod_next = s3_dr_reg * s3_dt_reg;
    assign s4_rcv_next  = rec_coupling_reg * s3_dr_reg;
    assign s4_rru_next  = $signed({1'b0, rec_rate_reg}) * s3_u_reg;

    // Stage 4: gain product split in two partial products; recovery change
    logic signed [49:0]        s4_prod_reg;
    logic signed [41:0]        s4_rcv_reg;
    logic signed [40:0]        s4_rru_reg;
    logic signed [25:0]        s4_vbase_reg;
    logic signed [STATE_W-1:0] s4_u_reg;
    logic signed [42:0]        s5_ph_next;
    logic [39:0]               s5_pl_next;
    logic signed [42:0]        s5_du_raw_next;

    assign s5_ph_next     = $signed(s4_prod_reg[49:24]) * $signed({1'b0, quad_gain_reg});
    assign s5_pl_next     = s4_prod_reg[23:0] * quad_gain_reg;
    assign s5_du_raw_next = 43'(s4_rcv_reg) - 43'(s4_rru_reg);

    // Stage 5: recombine partial products; round recovery change to Q.8
    localparam logic [42:0] DU_HALF = 43'd1 << 15;

    logic signed [42:0]        s5_ph_reg, s5_du_raw_reg;
    logic [39:0]               s5_pl_reg;
    logic signed [25:0]        s5_vbase_reg;
    logic signed [STATE_W-1:0] s5_u_reg;
    logic signed [66:0]        s6_qraw_next;
    logic [42:0]               du_rnd;
    logic signed [26:0]        s6_du_next;

    assign s6_qraw_next = $signed({s5_ph_reg, 24'b0}) + $signed({27'b0, s5_pl_reg});
    // Ties go away from zero: subtract one before the shift for negative values
    assign du_rnd       = s5_du_raw_reg + DU_HALF - {42'b0, s5_du_raw_reg[42]};
    assign s6_du_next   = du_rnd[42:16];

    // Stage 6: round the quadratic term; recovery update
    localparam logic [66:0] Q_HALF = 67'd1 << 23;

    logic signed [66:0]        s6_qraw_reg;
    logic signed [26:0]        s6_du_reg;
    logic signed [25:0]        s6_vbase_reg;
    logic signed [STATE_W-1:0] s6_u_reg;
    logic [66:0]               q_rnd;
    logic signed [39:0]        s7_quad_next;
    logic signed [STATE_W-1:0] s7_un_next;

    assign q_rnd        = s6_qraw_reg + Q_HALF - {66'b0, s6_qraw_reg[66]};
    assign s7_quad_next = q_rnd[63:24];
    assign s7_un_next   = sat24(48'(s6_u_reg) + 48'(s6_du_reg));

    // Stage 7: membrane sum, write-back and result
    logic signed [39:0]        s7_quad_reg;
    logic signed [25:0]        s7_vbase_reg;
    logic signed [STATE_W-1:0] s7_un_reg;
    logic signed [STATE_W-1:0] vn;
    qsn_out_t                  out_data_next;

    assign vn = sat24(48'(s7_quad_reg) + 48'(s7_vbase_reg));

    always_comb
    begin
        wr.en   = advance && s7_valid_reg && s7_tag_reg.in_range;
        wr.addr = s7_tag_reg.neuron[ADDR_W-1:0];
        wr.v    = vn;
        wr.u    = s7_un_reg;

        out_data_next.neuron_out = s7_tag_reg.neuron;
        out_data_next.spiked     = s7_tag_reg.spiked;
        out_data_next.membrane   = s7_tag_reg.in_range ? vn : '0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_tag_reg.neuron   <= in_data.neuron;
            s1_tag_reg.in_range <= in_range;
            s1_tag_reg.spiked   <= 1'b0;
            s1_drive_reg        <= in_data.drive;

            s2_tag_reg   <= s2_tag_next;
            s2_drive_reg <= s1_drive_reg;
            s2_v_reg     <= s2_v_next;
            s2_u_reg     <= s2_u_next;

            s3_tag_reg   <= s2_tag_reg;
            s3_dr_reg    <= s3_dr_next;
            s3_dt_reg    <= s3_dt_next;
            s3_vbase_reg <= s3_vbase_next;
            s3_u_reg     <= s2_u_reg;

            s4_tag_reg   <= s3_tag_reg;
            s4_prod_reg  <= s4_prod_next;
            s4_rcv_reg   <= s4_rcv_next;
            s4_rru_reg   <= s4_rru_next;
            s4_vbase_reg <= s3_vbase_reg;
            s4_u_reg     <= s3_u_reg;

            s5_tag_reg    <= s4_tag_reg;
            s5_ph_reg     <= s5_ph_next;
            s5_pl_reg     <= s5_pl_next;
            s5_du_raw_reg <= s5_du_raw_next;
            s5_vbase_reg  <= s4_vbase_reg;
            s5_u_reg      <= s4_u_reg;

            s6_tag_reg   <= s5_tag_reg;
            s6_qraw_reg  <= s6_qraw_next;
            s6_du_reg    <= s6_du_next;
            s6_vbase_reg <= s5_vbase_reg;
            s6_u_reg     <= s5_u_reg;

            s7_tag_reg   <= s6_tag_reg;
            s7_quad_reg  <= s7_quad_next;
            s7_vbase_reg <= s6_vbase_reg;
            s7_un_reg    <= s7_un_next;

            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A write-back must never target a neuron still waiting upstream
    assign wr_collide = hit(s1_valid_reg, s1_tag_reg, s7_tag_reg.neuron)
                     || hit(s2_valid_reg, s2_tag_reg, s7_tag_reg.neuron)
                     || hit(s3_valid_reg, s3_tag_reg, s7_tag_reg.neuron)
                     || hit(s4_valid_reg, s4_tag_reg, s7_tag_reg.neuron)
                     || hit(s5_valid_reg, s5_tag_reg, s7_tag_reg.neuron)
                     || hit(s6_valid_reg, s6_tag_reg, s7_tag_reg.neuron);

    a_no_raw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !wr_collide)
        else $error("write-back collides with an in-flight update of the same neuron");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg,
                              s5_valid_reg, s6_valid_reg, s7_valid_reg, out_valid_reg}))
        else $error("pipeline moved during an output stall");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transfer did not enter stage 1");

    a_sweep_once: assert property (@(posedge clk) disable iff (!rst_n)
        !mem_busy |=> !mem_busy)
        else $error("state clearing sweep restarted");

endmodule

>>> hdl/qsn_state_mem.sv
// Membrane and recovery state memories with the post-reset clearing sweep.
// Depends on qsn_pkg.
module qsn_state_mem (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [qsn_pkg::ADDR_W-1:0]        rd_addr,
    input  qsn_pkg::qsn_wr_t                  wr,
    output logic signed [qsn_pkg::STATE_W-1:0] rd_v,
    output logic signed [qsn_pkg::STATE_W-1:0] rd_u,
    output logic                              busy
);
    import qsn_pkg::*;

    logic signed [STATE_W-1:0] mem_v [NEURONS];
    logic signed [STATE_W-1:0] mem_u [NEURONS];

    logic [ADDR_W-1:0]         clr_cnt_reg;
    logic                      busy_reg;
    logic signed [STATE_W-1:0] rd_v_reg;
    logic signed [STATE_W-1:0] rd_u_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(NEURONS - 1))
                busy_reg <= 1'b0;
        end
    end

    // Sweep loads the reset values; no transfers are taken while it runs.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem_v[clr_cnt_reg] <= STATE_W'(V_RESET_INIT);
            mem_u[clr_cnt_reg] <= '0;
        end
        else if (wr.en)
        begin
            mem_v[wr.addr] <= wr.v;
            mem_u[wr.addr] <= wr.u;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_v_reg <= mem_v[rd_addr];
            rd_u_reg <= mem_u[rd_addr];
        end
    end

    assign rd_v = rd_v_reg;
    assign rd_u = rd_u_reg;
    assign busy = busy_reg;

endmodule

>>> test/tb_quadratic_spiking_neuron_array.sv
`timescale 1ns / 100ps
// Testbench for quadratic_spiking_neuron_array: random and directed neuron ticks,
// expected membrane updates predicted per transfer and checked in order.
// Depends on qsn_pkg and the quadratic_spiking_neuron_array RTL.

import qsn_pkg::*;

class neuron_scoreboard;
    // shadow copy of the register file, widened for the arithmetic
    longint rest_pot, thres_pot, peak_pot, reset_pot, jump_rec;
    longint gain_quad, decay_rec, couple_rec;
    logic signed [STATE_W-1:0] pot_mem [NEURONS];
    logic signed [STATE_W-1:0] rec_mem [NEURONS];
    qsn_out_t pending_updates [$];
    int mismatches;

    function new();
        rest_pot   = longint'(V_REST_INIT);
        thres_pot  = longint'(V_THRES_INIT);
        peak_pot   = longint'(V_PEAK_INIT);
        reset_pot  = longint'(V_RESET_INIT);
        jump_rec   = longint'(U_JUMP_INIT);
        gain_quad  = longint'(QUAD_GAIN_INIT);
        decay_rec  = longint'(REC_RATE_INIT);
        couple_rec = longint'(REC_COUPLING_INIT);
        for (int i = 0; i < NEURONS; i++)
        begin
            pot_mem[i] = STATE_W'(V_RESET_INIT);
            rec_mem[i] = '0;
        end
        mismatches = 0;
    endfunction

    function void set_reg(qsn_cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_V_REST:       rest_pot   = longint'($signed(value[15:0]));
            CFG_V_THRES:      thres_pot  = longint'($signed(value[15:0]));
            CFG_V_PEAK:       peak_pot   = longint'($signed(value[15:0]));
            CFG_V_RESET:      reset_pot  = longint'($signed(value[15:0]));
            CFG_U_JUMP:       jump_rec   = longint'($signed(value[15:0]));
            CFG_QUAD_GAIN:    gain_quad  = longint'(value[15:0]);
            CFG_REC_RATE:     decay_rec  = longint'(value[15:0]);
            CFG_REC_COUPLING: couple_rec = longint'($signed(value));
            default: ;
        endcase
    endfunction

    function longint clamp_state(longint x);
        if (x > longint'(SAT_MAX))
            return longint'(SAT_MAX);
        if (x < longint'(SAT_MIN))
            return longint'(SAT_MIN);
        return x;
    endfunction

    // round to nearest, ties away from zero
    function longint round_q(longint x, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (x >= 0)
            return (x + half) >>> s;
        return -((-x + half) >>> s);
    endfunction

    function void note_tick(qsn_in_t tick);
        qsn_out_t res;
        longint v, u, dr, dth, quad, du, vn, un, drv;
        int idx;
        idx = int'(tick.neuron);
        drv = longint'($signed(tick.drive));
        res.neuron_out = tick.neuron;
        res.spiked = 1'b0;
        res.membrane = '0;
        if (idx < NEURONS)
        begin
            v = pot_mem[idx];
            u = rec_mem[idx];
            if (v > peak_pot)
            begin
                res.spiked = 1'b1;
                v = reset_pot;
                u = clamp_state(u + jump_rec);
            end
            dr = v - rest_pot;
            dth = v - thres_pot;
            quad = round_q(dr * dth * gain_quad, 24);
            du = round_q(couple_rec * dr - decay_rec * u, 16);
            vn = clamp_state(v + quad - u + drv);
            un = clamp_state(u + du);
            pot_mem[idx] = vn[STATE_W-1:0];
            rec_mem[idx] = un[STATE_W-1:0];
            res.membrane = vn[STATE_W-1:0];
        end
        pending_updates.push_back(res);
    endfunction

    function void check_update(qsn_out_t got);
        qsn_out_t exp_upd;
        if (pending_updates.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected update: neuron=%0d spiked=%0b membrane=%0d",
                         got.neuron_out, got.spiked, $signed(got.membrane));
            return;
        end
        exp_upd = pending_updates.pop_front();
        if (got.neuron_out !== exp_upd.neuron_out || got.spiked !== exp_upd.spiked ||
            got.membrane !== exp_upd.membrane)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected neuron %0d spiked %0b v %0d, got %0d %0b %0d",
                         exp_upd.neuron_out, exp_upd.spiked, $signed(exp_upd.membrane),
                         got.neuron_out, got.spiked, $signed(got.membrane));
        end
    endfunction

    function int pending();
        return pending_updates.size();
    endfunction
endclass

module tb_quadratic_spiking_neuron_array;

    localparam int PHASES          = 10;
    localparam int TICKS_PER_PHASE = 153;
    localparam int SETTLE_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT  = 6000;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC,
        RDY_BURSTS
    } ready_mode_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    qsn_in_t in_data;
    logic out_valid;
    logic out_ready = 1'b0;
    qsn_out_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    neuron_scoreboard sb;
    int burst_left;
    int quiet_cycles = 0;
    int unsigned ready_cycle = 0;
    int stall_left = 0;
    ready_mode_t ready_mode = RDY_ALWAYS;

    quadratic_spiking_neuron_array u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver stall pattern: always ready, random, periodic or bursts, style picked at random
    always @(posedge clk)
    begin
        if (ready_cycle % 256 == 0)
            ready_mode = ready_mode_t'($urandom_range(0, 3));
        ready_cycle++;
        case (ready_mode)
            RDY_ALWAYS:   out_ready <= 1'b1;
            RDY_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
            RDY_PERIODIC: out_ready <= ((ready_cycle % 7) >= 3);
            default:
            begin
                if (stall_left != 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    stall_left = $urandom_range(1, 24);
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_update(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    function automatic qsn_in_t tick_of(int n, int d);
        qsn_in_t t;
        t.neuron = n[NEURON_W-1:0];
        t.drive = d[DRIVE_W-1:0];
        return t;
    endfunction

    // mostly a small hot set of neurons so that they climb to the peak and fire
    function automatic qsn_in_t random_tick(int hot_base);
        int n, d, r;
        if ($urandom_range(0, 9) < 7)
            n = hot_base + int'($urandom_range(0, 11));
        else
            n = int'($urandom_range(0, 1023));
        r = $urandom_range(0, 99);
        if (r < 55)
            d = int'($urandom_range(0, 5120)) - 1024;
        else if (r < 75)
            d = int'($urandom_range(0, 131072)) - 65536;
        else if (r < 90)
            d = int'($urandom());
        else
            case ($urandom_range(0, 3))
                0: d = 8388607;
                1: d = -8388608;
                2: d = 0;
                default: d = -1;
            endcase
        return tick_of(n, d);
    endfunction

    task automatic issue_tick(input qsn_in_t tick);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= tick;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_tick(tick);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input qsn_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic configure(input int rest, thres, peak, after,
                             jump, gain, rate, coupling);
        write_reg(CFG_V_REST, CFG_DATA_W'(rest));
        write_reg(CFG_V_THRES, CFG_DATA_W'(thres));
        write_reg(CFG_V_PEAK, CFG_DATA_W'(peak));
        write_reg(CFG_V_RESET, CFG_DATA_W'(after));
        write_reg(CFG_U_JUMP, CFG_DATA_W'(jump));
        write_reg(CFG_QUAD_GAIN, CFG_DATA_W'(gain));
        write_reg(CFG_REC_RATE, CFG_DATA_W'(rate));
        write_reg(CFG_REC_COUPLING, CFG_DATA_W'(coupling));
        cfg_we <= 1'b0;
    endtask

    // reset settings: no recovery, field extremes, saturation both ways, repeat hazards
    task automatic run_directed();
        issue_tick(tick_of(0, 0));
        issue_tick(tick_of(1023, 0));
        issue_tick(tick_of(5, 8388607));
        issue_tick(tick_of(5, 0));
        issue_tick(tick_of(5, 0));
        issue_tick(tick_of(6, -8388608));
        issue_tick(tick_of(6, -8388608));
        issue_tick(tick_of(6, 0));
        issue_tick(tick_of(7, -1));
        issue_tick(tick_of(8, 1));
        issue_tick(tick_of('h2AA, 'h555555));
        issue_tick(tick_of('h155, -'h555556));
        for (int i = 0; i < 7; i++)
            issue_tick(tick_of(9, 5120));
        issue_tick(tick_of(512, 256));
        issue_tick(tick_of(1023, -8388608));
        issue_tick(tick_of(0, 8388607));
    endtask

    task automatic run_phase(input int p);
        int hot_base;
        hot_base = $urandom_range(0, 1023);
        case (p)
            1: configure(-15360, -10240, 7680, -12800, 256, 459, 1966, -3932);
            2: configure(32767, 32767, 32767, 32767, 32767, 65535, 65535, 65535);
            3: configure(-32768, -32768, -32768, -32768, -32768, 0, 0, -65536);
            4: configure(-15360, -10240, 7680, -12800, 32767, 459, 0, 65535);
            default:
                if ($urandom_range(0, 1) == 0)
                    configure(-15360 + int'($urandom_range(0, 2560)) - 1280,
                              -10240 + int'($urandom_range(0, 2560)) - 1280,
                              7680 + int'($urandom_range(0, 2560)) - 1280,
                              -12800 + int'($urandom_range(0, 2560)) - 1280,
                              $urandom_range(0, 2048),
                              259 + $urandom_range(0, 1000),
                              $urandom_range(0, 4000),
                              int'($urandom_range(0, 16000)) - 8000);
                else
                    configure($urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), $urandom(), $urandom());
        endcase
        for (int k = 0; k < TICKS_PER_PHASE; k++)
        begin
            if ((p == 1 && k == TICKS_PER_PHASE / 2) || $urandom_range(0, 149) == 0)
                drain_pipeline();
            issue_tick(random_tick(hot_base));
        end
        drain_pipeline();
    endtask

    initial
    begin
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_V_REST;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        drain_pipeline();
        for (int p = 1; p <= PHASES; p++)
            run_phase(p);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
